// ----- rtl/rmm_pkg.sv -----
// Shared types, widths and constants for the radar measurement model.
package rmm_pkg;

  localparam int COORD_W       = 32;
  localparam int CORDIC_STAGES = 30;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int MAG_W         = COORD_W;
  localparam int SQ_W          = 2 * MAG_W;
  localparam int ROOT_W        = MAG_W + 1;
  localparam int RAD_W         = 2 * ROOT_W;
  localparam int REM_W         = ROOT_W + 2;
  localparam int CW            = 64;
  localparam int NORM_TOP      = 60;
  localparam int NORM_STEPS    = 6;
  localparam int SH_W          = 6;
  localparam int STG_W         = $clog2(CORDIC_STAGES);
  localparam int ANGLE_W       = 32;
  localparam int FIRST_W       = 35;
  localparam int LANES         = 2;
  localparam int MODE_W        = 2;

  localparam logic signed [ANGLE_W-1:0] ANGLE_PI = 32'sd843314857;

  typedef enum logic [MODE_W-1:0] {
    MODE_PASS = 2'd0,
    MODE_RAE  = 2'd1,
    MODE_BEAR = 2'd2
  } mode_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
    logic signed [COORD_W-1:0] station_x;
    logic signed [COORD_W-1:0] station_y;
    logic signed [COORD_W-1:0] station_z;
    logic                      last_station;
  } in_item_t;

  typedef struct packed {
    logic signed [FIRST_W-1:0] meas_first;
    logic signed [ANGLE_W-1:0] meas_second;
    logic signed [ANGLE_W-1:0] meas_third;
    logic                      last_out;
  } out_item_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic signed [CW-1:0]      x;
    logic signed [CW-1:0]      y;
    logic signed [ANGLE_W-1:0] z;
    logic [CW-1:0]             m;
    logic                      zero;
  } cor_t;

  function automatic logic signed [ANGLE_W-1:0] atan_tab(input int unsigned i);
    logic signed [ANGLE_W-1:0] v;
    v = '0;
    if (i >= 10 && i <= 28) begin
      v = ANGLE_W'(64'd1 << (28 - i));
    end else begin
      case (i)
        0: v = 32'sd210828714;
        1: v = 32'sd124459457;
        2: v = 32'sd65760959;
        3: v = 32'sd33381290;
        4: v = 32'sd16755422;
        5: v = 32'sd8385879;
        6: v = 32'sd4193963;
        7: v = 32'sd2097109;
        8: v = 32'sd1048571;
        9: v = 32'sd524287;
        default: v = '0;
      endcase
    end
    return v;
  endfunction

endpackage

// ----- rtl/rmm_sqrt_cell.sv -----
// One digit cell of the square root chain, two independent lanes.
module rmm_sqrt_cell (
  input  logic        clk,
  input  logic        en,
  input  rmm_pkg::sq_t lane_i [rmm_pkg::LANES],
  output rmm_pkg::sq_t lane_o [rmm_pkg::LANES]
);

  rmm_pkg::sq_t lane_r   [rmm_pkg::LANES];
  rmm_pkg::sq_t lane_nxt [rmm_pkg::LANES];

  always_comb begin
    logic [rmm_pkg::REM_W-1:0] rem_sh;
    logic [rmm_pkg::REM_W-1:0] trial;
    for (int l = 0; l < rmm_pkg::LANES; l++) begin
      rem_sh = {lane_i[l].rem[rmm_pkg::REM_W-3:0],
                lane_i[l].rad[rmm_pkg::RAD_W-1 -: 2]};
      trial = {lane_i[l].root, 2'b01};
      lane_nxt[l].rad = {lane_i[l].rad[rmm_pkg::RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        lane_nxt[l].rem  = rem_sh - trial;
        lane_nxt[l].root = {lane_i[l].root[rmm_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        lane_nxt[l].rem  = rem_sh;
        lane_nxt[l].root = {lane_i[l].root[rmm_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

// ----- rtl/rmm_norm_cell.sv -----
// One binary step of the CORDIC input normalization, two lanes.
module rmm_norm_cell (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rmm_pkg::SH_W-1:0]   sh,
  input  rmm_pkg::cor_t              lane_i [rmm_pkg::LANES],
  output rmm_pkg::cor_t              lane_o [rmm_pkg::LANES]
);

  rmm_pkg::cor_t lane_r   [rmm_pkg::LANES];
  rmm_pkg::cor_t lane_nxt [rmm_pkg::LANES];

  always_comb begin
    for (int l = 0; l < rmm_pkg::LANES; l++) begin
      lane_nxt[l] = lane_i[l];
      if ((lane_i[l].m >> (rmm_pkg::NORM_TOP - int'(sh))) == '0) begin
        lane_nxt[l].x = lane_i[l].x <<< sh;
        lane_nxt[l].y = lane_i[l].y <<< sh;
        lane_nxt[l].m = lane_i[l].m << sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

// ----- rtl/rmm_cordic_cell.sv -----
// One vectoring CORDIC rotation cell, two lanes.
module rmm_cordic_cell (
  input  logic                              clk,
  input  logic                              en,
  input  logic [rmm_pkg::STG_W-1:0]         stage,
  input  logic signed [rmm_pkg::ANGLE_W-1:0] atan_c,
  input  rmm_pkg::cor_t                     lane_i [rmm_pkg::LANES],
  output rmm_pkg::cor_t                     lane_o [rmm_pkg::LANES]
);

  rmm_pkg::cor_t lane_r   [rmm_pkg::LANES];
  rmm_pkg::cor_t lane_nxt [rmm_pkg::LANES];

  always_comb begin
    logic signed [rmm_pkg::CW-1:0] xs;
    logic signed [rmm_pkg::CW-1:0] ys;
    for (int l = 0; l < rmm_pkg::LANES; l++) begin
      xs = lane_i[l].x >>> stage;
      ys = lane_i[l].y >>> stage;
      lane_nxt[l] = lane_i[l];
      if (!lane_i[l].y[rmm_pkg::CW-1]) begin
        lane_nxt[l].x = lane_i[l].x + ys;
        lane_nxt[l].y = lane_i[l].y - xs;
        lane_nxt[l].z = lane_i[l].z + atan_c;
      end else begin
        lane_nxt[l].x = lane_i[l].x - ys;
        lane_nxt[l].y = lane_i[l].y + xs;
        lane_nxt[l].z = lane_i[l].z - atan_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

// ----- rtl/radar_measurement_model.sv -----
// Top level of the radar measurement model: range and angle pipeline, with a pass-through mode.
// The block takes one item per clock while the output is not stalled and returns its
// measurement through the difference, squaring and summing registers, a 33-cell square root
// chain, an angle setup register, 6 normalization cells, 30 CORDIC cells and the output register.
// When the result is not taken the whole pipeline holds, and it moves again as soon as the
// output register is free. The mode register is sampled as an item enters.
module radar_measurement_model (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rmm_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rmm_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [rmm_pkg::MODE_W-1:0]    cfg_wdata
);

  localparam int NC  = rmm_pkg::NORM_STEPS + rmm_pkg::CORDIC_STAGES;
  localparam int LAT = 4 + rmm_pkg::ROOT_W + NC;

  typedef struct packed {
    logic signed [rmm_pkg::DIFF_W-1:0]  dx;
    logic signed [rmm_pkg::DIFF_W-1:0]  dy;
    logic signed [rmm_pkg::DIFF_W-1:0]  dz;
    logic signed [rmm_pkg::COORD_W-1:0] tx;
    logic signed [rmm_pkg::COORD_W-1:0] ty;
    logic signed [rmm_pkg::COORD_W-1:0] tz;
    rmm_pkg::mode_t                     mode;
    logic                               last;
  } s1_t;

  typedef struct packed {
    logic signed [rmm_pkg::DIFF_W-1:0]  a1y;
    logic signed [rmm_pkg::DIFF_W-1:0]  a1x;
    logic signed [rmm_pkg::DIFF_W-1:0]  a2y;
    logic signed [rmm_pkg::COORD_W-1:0] tx;
    logic signed [rmm_pkg::COORD_W-1:0] ty;
    logic signed [rmm_pkg::COORD_W-1:0] tz;
    rmm_pkg::mode_t                     mode;
    logic                               last;
  } side_t;

  typedef struct packed {
    logic signed [rmm_pkg::COORD_W-1:0] tx;
    logic signed [rmm_pkg::COORD_W-1:0] ty;
    logic signed [rmm_pkg::COORD_W-1:0] tz;
    rmm_pkg::mode_t                     mode;
    logic                               last;
    logic [rmm_pkg::ROOT_W-1:0]         root3;
  } pt_t;

  logic                      en;
  rmm_pkg::mode_t            mode_r;
  logic [LAT-1:0]            vld_r;
  s1_t                       s1_r;
  logic [rmm_pkg::SQ_W-1:0]  sqx_r, sqy_r, sqz_r;
  side_t                     s2_side_r;
  rmm_pkg::sq_t              s3_lane_r [rmm_pkg::LANES];
  side_t                     s3_side_r;
  side_t                     side_r [rmm_pkg::ROOT_W];
  rmm_pkg::sq_t              sq_w [rmm_pkg::ROOT_W+1][rmm_pkg::LANES];
  rmm_pkg::cor_t             prep_r [rmm_pkg::LANES];
  rmm_pkg::cor_t             cor_w [NC+1][rmm_pkg::LANES];
  pt_t                       pt_r [NC+1];
  logic                      out_valid_r;
  rmm_pkg::out_item_t        out_r;
  rmm_pkg::out_item_t        out_nxt;
  side_t                     s2_side_nxt;
  logic [rmm_pkg::MAG_W-1:0] mx, my, mz;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  function automatic rmm_pkg::cor_t prep(input logic signed [rmm_pkg::CW-1:0] y,
                                         input logic signed [rmm_pkg::CW-1:0] x);
    rmm_pkg::cor_t             c;
    logic [rmm_pkg::CW-1:0]    my_abs;
    c.zero = (x == '0) && (y == '0);
    if (x[rmm_pkg::CW-1]) begin
      c.x = -x;
      c.y = -y;
      c.z = y[rmm_pkg::CW-1] ? -rmm_pkg::ANGLE_PI : rmm_pkg::ANGLE_PI;
    end else begin
      c.x = x;
      c.y = y;
      c.z = '0;
    end
    my_abs = c.y[rmm_pkg::CW-1] ? -c.y : c.y;
    c.m = c.x | my_abs;
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rmm_pkg::MODE_RAE;
    end else if (cfg_we) begin
      mode_r <= rmm_pkg::mode_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT-2:0], in_valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_comb begin
    mx = rmm_pkg::MAG_W'(s1_r.dx[rmm_pkg::DIFF_W-1] ? -s1_r.dx : s1_r.dx);
    my = rmm_pkg::MAG_W'(s1_r.dy[rmm_pkg::DIFF_W-1] ? -s1_r.dy : s1_r.dy);
    mz = rmm_pkg::MAG_W'(s1_r.dz[rmm_pkg::DIFF_W-1] ? -s1_r.dz : s1_r.dz);
    s2_side_nxt.a1x  = s1_r.dx;
    s2_side_nxt.tx   = s1_r.tx;
    s2_side_nxt.ty   = s1_r.ty;
    s2_side_nxt.tz   = s1_r.tz;
    s2_side_nxt.mode = s1_r.mode;
    s2_side_nxt.last = s1_r.last;
    if (s1_r.mode == rmm_pkg::MODE_BEAR) begin
      s2_side_nxt.a1y = -s1_r.dz;
      s2_side_nxt.a2y = s1_r.dy;
    end else begin
      s2_side_nxt.a1y = s1_r.dy;
      s2_side_nxt.a2y = s1_r.dz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.dx   <= rmm_pkg::DIFF_W'(in_item.target_x) - rmm_pkg::DIFF_W'(in_item.station_x);
      s1_r.dy   <= rmm_pkg::DIFF_W'(in_item.target_y) - rmm_pkg::DIFF_W'(in_item.station_y);
      s1_r.dz   <= rmm_pkg::DIFF_W'(in_item.target_z) - rmm_pkg::DIFF_W'(in_item.station_z);
      s1_r.tx   <= in_item.target_x;
      s1_r.ty   <= in_item.target_y;
      s1_r.tz   <= in_item.target_z;
      s1_r.mode <= mode_r;
      s1_r.last <= in_item.last_station;

      sqx_r     <= mx * mx;
      sqy_r     <= my * my;
      sqz_r     <= mz * mz;
      s2_side_r <= s2_side_nxt;

      s3_lane_r[0].rad  <= rmm_pkg::RAD_W'(sqx_r) + rmm_pkg::RAD_W'(sqy_r)
                           + rmm_pkg::RAD_W'(sqz_r);
      s3_lane_r[0].rem  <= '0;
      s3_lane_r[0].root <= '0;
      s3_lane_r[1].rad  <= rmm_pkg::RAD_W'(sqx_r) + rmm_pkg::RAD_W'(
                             (s2_side_r.mode == rmm_pkg::MODE_BEAR) ? sqz_r : sqy_r);
      s3_lane_r[1].rem  <= '0;
      s3_lane_r[1].root <= '0;
      s3_side_r         <= s2_side_r;

      side_r[0] <= s3_side_r;
      for (int k = 1; k < rmm_pkg::ROOT_W; k++) begin
        side_r[k] <= side_r[k-1];
      end

      prep_r[0] <= prep(rmm_pkg::CW'(side_r[rmm_pkg::ROOT_W-1].a1y),
                        rmm_pkg::CW'(side_r[rmm_pkg::ROOT_W-1].a1x));
      prep_r[1] <= prep(rmm_pkg::CW'(side_r[rmm_pkg::ROOT_W-1].a2y),
                        rmm_pkg::CW'(sq_w[rmm_pkg::ROOT_W][1].root));
      pt_r[0].tx    <= side_r[rmm_pkg::ROOT_W-1].tx;
      pt_r[0].ty    <= side_r[rmm_pkg::ROOT_W-1].ty;
      pt_r[0].tz    <= side_r[rmm_pkg::ROOT_W-1].tz;
      pt_r[0].mode  <= side_r[rmm_pkg::ROOT_W-1].mode;
      pt_r[0].last  <= side_r[rmm_pkg::ROOT_W-1].last;
      pt_r[0].root3 <= sq_w[rmm_pkg::ROOT_W][0].root;
      for (int k = 1; k <= NC; k++) begin
        pt_r[k] <= pt_r[k-1];
      end

      out_r <= out_nxt;
    end
  end

  assign sq_w[0]  = s3_lane_r;
  assign cor_w[0] = prep_r;

  for (genvar k = 0; k < rmm_pkg::ROOT_W; k++) begin : g_sqrt
    rmm_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en),
      .lane_i (sq_w[k]),
      .lane_o (sq_w[k+1])
    );
  end

  for (genvar j = 0; j < rmm_pkg::NORM_STEPS; j++) begin : g_norm
    rmm_norm_cell u_cell (
      .clk    (clk),
      .en     (en),
      .sh     (rmm_pkg::SH_W'(32'd1 << (rmm_pkg::NORM_STEPS - 1 - j))),
      .lane_i (cor_w[j]),
      .lane_o (cor_w[j+1])
    );
  end

  for (genvar i = 0; i < rmm_pkg::CORDIC_STAGES; i++) begin : g_cordic
    rmm_cordic_cell u_cell (
      .clk    (clk),
      .en     (en),
      .stage  (rmm_pkg::STG_W'(i)),
      .atan_c (rmm_pkg::atan_tab(i)),
      .lane_i (cor_w[rmm_pkg::NORM_STEPS+i]),
      .lane_o (cor_w[rmm_pkg::NORM_STEPS+i+1])
    );
  end

  always_comb begin
    logic signed [rmm_pkg::ANGLE_W-1:0] z0;
    logic signed [rmm_pkg::ANGLE_W-1:0] z1;
    z0 = cor_w[NC][0].zero ? '0 : cor_w[NC][0].z;
    z1 = cor_w[NC][1].zero ? '0 : cor_w[NC][1].z;
    out_nxt          = '0;
    out_nxt.last_out = pt_r[NC].last;
    case (pt_r[NC].mode)
      rmm_pkg::MODE_PASS: begin
        out_nxt.meas_first  = rmm_pkg::FIRST_W'(pt_r[NC].tx);
        out_nxt.meas_second = rmm_pkg::ANGLE_W'(pt_r[NC].ty);
        out_nxt.meas_third  = rmm_pkg::ANGLE_W'(pt_r[NC].tz);
      end
      rmm_pkg::MODE_RAE: begin
        out_nxt.meas_first  = rmm_pkg::FIRST_W'(pt_r[NC].root3);
        out_nxt.meas_second = z0;
        out_nxt.meas_third  = z1;
      end
      rmm_pkg::MODE_BEAR: begin
        out_nxt.meas_first  = rmm_pkg::FIRST_W'(z0);
        out_nxt.meas_second = z1;
      end
      default: begin
        out_nxt.meas_first = '0;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(vld_r))
    else $error("Pipeline moved while the output was stalled.");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("Accepted item did not enter the pipeline.");

  a_root_order: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[rmm_pkg::ROOT_W+2] |-> (sq_w[rmm_pkg::ROOT_W][0].root >= sq_w[rmm_pkg::ROOT_W][1].root))
    else $error("Range root is below the planar root.");

endmodule
